### rtl/ccnm_pkg.sv
package ccnm_pkg;

    localparam int PERIOD_W = 20;
    localparam int STATUS_W = 2;
    localparam int COLOR_W  = 3;
    localparam int DIST_W   = 22;
    localparam int LANES    = 3;

    localparam logic [STATUS_W-1:0] STATUS_SAMPLE     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_STORED     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CLASSIFIED = 2'd2;

    typedef struct packed {
        logic [PERIOD_W-1:0] red_period;
        logic [PERIOD_W-1:0] green_period;
        logic [PERIOD_W-1:0] blue_period;
    } ccnm_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [COLOR_W-1:0]  color_index;
        logic [DIST_W-1:0]   best_distance;
    } ccnm_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_STORE,
        ST_SCAN,
        ST_DONE
    } ccnm_state_t;

endpackage

### rtl/color_calibrate_and_nearest_match.sv
// Channel   Ports                          Moves
// input     s_valid, s_ready, s_data       one red/green/blue pulse-width triple
// result    m_valid, m_ready, m_data       status, color index, best distance
//
// A sample that does not close its group goes from ST_IDLE straight to ST_DONE; the one that
// closes it also passes ST_DIVIDE and ST_STORE: one shared multiplier divides the sums by
// SAMPLES_PER_COLOR, a lane a cycle. A classification reads one reference per cycle through
// a two-stage distance and compare pipeline.
// Reset (aresetn low at a clock edge) restarts calibration at the first color.
// A result waiting on m_ready does not block the next input transaction; the following result waits in ST_DONE.
module color_calibrate_and_nearest_match #(
    parameter int NUM_COLORS        = 7,
    parameter int SAMPLES_PER_COLOR = 5
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ccnm_pkg::ccnm_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ccnm_pkg::ccnm_out_t m_data
);
    import ccnm_pkg::*;

    localparam int IDX_W    = $clog2(NUM_COLORS);
    localparam int STAGE_W  = $clog2(NUM_COLORS + 1);
    localparam int SUM_W    = PERIOD_W + $clog2(SAMPLES_PER_COLOR);
    localparam int CNT_W    = $clog2(SAMPLES_PER_COLOR + 1);
    localparam int DSTEP_W  = $clog2(LANES);
    localparam int ENTRY_W  = LANES * PERIOD_W;
    localparam int RECIP_SH = SUM_W + $clog2(SAMPLES_PER_COLOR);
    localparam int RECIP_W  = SUM_W + 1;
    localparam int PROD_W   = SUM_W + RECIP_W;

    localparam longint RECIP_L = ((longint'(1) << RECIP_SH) + longint'(SAMPLES_PER_COLOR - 1))
                                 / longint'(SAMPLES_PER_COLOR);

    localparam logic [RECIP_W-1:0] RECIP     = RECIP_W'(RECIP_L);
    localparam logic [STAGE_W-1:0] COLORS    = STAGE_W'(NUM_COLORS);
    localparam logic [CNT_W-1:0]   GROUP_LEN = CNT_W'(SAMPLES_PER_COLOR);
    localparam logic [DSTEP_W-1:0] LAST_STEP = DSTEP_W'(LANES - 1);

    ccnm_state_t state_reg, state_next;

    logic [STAGE_W-1:0] stage_reg, stage_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   count_inc;
    logic [SUM_W-1:0]   sum_reg [LANES];
    logic [SUM_W-1:0]   sum_next [LANES];
    logic [DSTEP_W-1:0] div_cnt_reg, div_cnt_next;
    ccnm_in_t           in_reg, in_next;

    logic [STAGE_W-1:0] rd_cnt_reg, rd_cnt_next;
    logic               rd_en;
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [DIST_W-1:0]  dist_reg;
    logic               dist_vld_reg;
    logic [IDX_W-1:0]   dist_idx_reg;
    logic [DIST_W-1:0]  best_reg, best_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic               scan_done;

    ccnm_out_t          res_reg, res_next;
    logic               m_valid_reg, m_valid_next;
    ccnm_out_t          m_data_reg, m_data_next;

    logic               mem_we;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ENTRY_W-1:0] mem [NUM_COLORS];

    logic [PERIOD_W-1:0] s_lane [LANES];
    logic [PERIOD_W-1:0] in_lane [LANES];
    logic [PERIOD_W-1:0] ref_lane [LANES];
    logic [DIST_W-1:0]   sad;

    assign s_lane[0]  = s_data.red_period;
    assign s_lane[1]  = s_data.green_period;
    assign s_lane[2]  = s_data.blue_period;
    assign in_lane[0] = in_reg.red_period;
    assign in_lane[1] = in_reg.green_period;
    assign in_lane[2] = in_reg.blue_period;

    assign count_inc = count_reg + CNT_W'(1);
    assign rd_en     = (state_reg == ST_SCAN) && (rd_cnt_reg < COLORS);
    assign scan_done = (rd_cnt_reg == COLORS) && !rd_vld_reg && !dist_vld_reg;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Sum of absolute differences between the held triple and one reference.
    always_comb begin
        logic [DIST_W-1:0] acc;
        acc = '0;
        for (int k = 0; k < LANES; k++) begin
            ref_lane[k] = rd_data_reg[k*PERIOD_W +: PERIOD_W];
            if (in_lane[k] >= ref_lane[k]) begin
                acc = acc + DIST_W'(in_lane[k] - ref_lane[k]);
            end else begin
                acc = acc + DIST_W'(ref_lane[k] - in_lane[k]);
            end
        end
        sad = acc;
    end

    always_comb begin
        for (int k = 0; k < LANES; k++) begin
            mem_wdata[k*PERIOD_W +: PERIOD_W] = sum_reg[k][PERIOD_W-1:0];
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (stage_reg < COLORS) begin
                        state_next = (count_inc == GROUP_LEN) ? ST_DIVIDE : ST_DONE;
                    end else begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_DIVIDE: begin
                if (div_cnt_reg == LAST_STEP) begin
                    state_next = ST_STORE;
                end
            end
            ST_STORE: begin
                state_next = ST_DONE;
            end
            ST_SCAN: begin
                if (scan_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        logic [PROD_W-1:0] prod;
        stage_next    = stage_reg;
        count_next    = count_reg;
        div_cnt_next  = div_cnt_reg;
        in_next       = in_reg;
        rd_cnt_next   = rd_cnt_reg;
        best_next     = best_reg;
        best_idx_next = best_idx_reg;
        res_next      = res_reg;
        mem_we        = 1'b0;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        prod          = '0;
        for (int k = 0; k < LANES; k++) begin
            sum_next[k] = sum_reg[k];
        end

        // Compare stage of the scan pipeline; strict less-than keeps the lowest index on ties.
        if (dist_vld_reg && (dist_reg < best_reg)) begin
            best_next     = dist_reg;
            best_idx_next = dist_idx_reg;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    in_next     = s_data;
                    best_next   = '1;
                    rd_cnt_next = '0;
                    if (stage_reg < COLORS) begin
                        for (int k = 0; k < LANES; k++) begin
                            sum_next[k] = sum_reg[k] + SUM_W'(s_lane[k]);
                        end
                        if (count_inc == GROUP_LEN) begin
                            count_next   = '0;
                            div_cnt_next = '0;
                        end else begin
                            count_next           = count_inc;
                            res_next.status        = STATUS_SAMPLE;
                            res_next.color_index   = COLOR_W'(stage_reg);
                            res_next.best_distance = '0;
                        end
                    end
                end
            end
            ST_DIVIDE: begin
                // The reciprocal is rounded up and wide enough that the top bits of the
                // product are the exact truncated quotient for any sum.
                prod = PROD_W'(sum_reg[div_cnt_reg]) * PROD_W'(RECIP);
                for (int k = 0; k < LANES; k++) begin
                    if (div_cnt_reg == DSTEP_W'(k)) begin
                        sum_next[k] = SUM_W'(prod[RECIP_SH +: PERIOD_W]);
                    end
                end
                div_cnt_next = div_cnt_reg + DSTEP_W'(1);
            end
            ST_STORE: begin
                mem_we = 1'b1;
                for (int k = 0; k < LANES; k++) begin
                    sum_next[k] = '0;
                end
                stage_next             = stage_reg + STAGE_W'(1);
                res_next.status        = STATUS_STORED;
                res_next.color_index   = COLOR_W'(stage_reg);
                res_next.best_distance = '0;
            end
            ST_SCAN: begin
                if (rd_en) begin
                    rd_cnt_next = rd_cnt_reg + STAGE_W'(1);
                end
                if (scan_done) begin
                    res_next.status        = STATUS_CLASSIFIED;
                    res_next.color_index   = COLOR_W'(best_idx_reg);
                    res_next.best_distance = best_reg;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[stage_reg[IDX_W-1:0]] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_cnt_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            stage_reg    <= '0;
            count_reg    <= '0;
            div_cnt_reg  <= '0;
            rd_cnt_reg   <= '0;
            rd_vld_reg   <= 1'b0;
            dist_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            for (int k = 0; k < LANES; k++) begin
                sum_reg[k] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            stage_reg    <= stage_next;
            count_reg    <= count_next;
            div_cnt_reg  <= div_cnt_next;
            rd_cnt_reg   <= rd_cnt_next;
            rd_vld_reg   <= rd_en;
            dist_vld_reg <= rd_vld_reg;
            m_valid_reg  <= m_valid_next;
            for (int k = 0; k < LANES; k++) begin
                sum_reg[k] <= sum_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        in_reg       <= in_next;
        rd_idx_reg   <= rd_cnt_reg[IDX_W-1:0];
        dist_reg     <= sad;
        dist_idx_reg <= rd_idx_reg;
        best_reg     <= best_next;
        best_idx_reg <= best_idx_next;
        res_reg      <= res_next;
        m_data_reg   <= m_data_next;
    end

endmodule
